FILE: rtl/es2cal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2cal_pkg
// Shared types, constants and the month length table for the epoch seconds
// to calendar converter.
// ----------------------------------------------------------------------------
package es2cal_pkg;

    localparam int unsigned SecsPerDay  = 86400;
    localparam int unsigned SecsPerHour = 3600;
    localparam int unsigned SecsPerMin  = 60;
    localparam int unsigned BaseYear    = 1970;

    localparam int unsigned EpochW = 32;
    localparam int unsigned DaysW  = 16;   // at most 49710 days
    localparam int unsigned RemW   = 17;   // remainder below 86400
    localparam int unsigned YearW  = 12;
    localparam int unsigned MonthW = 4;
    localparam int unsigned DayW   = 5;
    localparam int unsigned HourW  = 5;
    localparam int unsigned MinW   = 6;
    localparam int unsigned YlenW  = 9;

    // Division by a constant as q = (n * Recip) >> Shift, where n is the
    // dividend with the divisor's power-of-two factor shifted out; exact over
    // the whole range of n
    localparam int unsigned DayPreShift  = 7;          // 86400 = 675 * 128
    localparam int unsigned DayProdW     = 51;
    localparam int unsigned DayRecip     = 50903317;   // ceil(2^35 / 675)
    localparam int unsigned DayShift     = 35;
    localparam int unsigned HourPreShift = 4;          // 3600 = 225 * 16
    localparam int unsigned HourProdW    = 27;
    localparam int unsigned HourRecip    = 9321;       // ceil(2^21 / 225)
    localparam int unsigned HourShift    = 21;
    localparam int unsigned MinPreShift  = 2;          // 60 = 15 * 4
    localparam int unsigned MinProdW     = 21;
    localparam int unsigned MinRecip     = 1093;       // ceil(2^14 / 15)
    localparam int unsigned MinShift     = 14;
    localparam int unsigned MinRemW      = 12;         // remainder below 3600

    // Year position within the 100 and 400 year cycles at the base year
    localparam int unsigned BaseMod100 = 70;
    localparam int unsigned BaseMod400 = 370;

    localparam logic [MonthW-1:0] LastMonth = MonthW'(11);
    localparam logic [MonthW-1:0] MonFeb    = MonthW'(1);

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN
    } div_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_YEAR,
        ST_MONTH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     load_in;
        logic     div_step;
        div_sel_t div_sel;
        logic     yr_step;
        logic     mo_step;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic yr_fits;
        logic mo_fits;
    } stat_t;

    // Days in month, month counted from 0
    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] mo,
                                                   input logic leap);
        logic [DayW-1:0] len;
        unique case (mo)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = DayW'(31);
            4'd3, 4'd5, 4'd8, 4'd10:                  len = DayW'(30);
            MonFeb:                                   len = leap ? DayW'(29) : DayW'(28);
            default:                                  len = DayW'(31);
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/es2cal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2cal_ctrl
// Sequencer: accepts a timestamp, steps the datapath through the division
// passes, the year loop and the month loop, then hands off to the output
// register.
// ----------------------------------------------------------------------------
module es2cal_ctrl
    import es2cal_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.div_sel  = DIV_DAY;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DAY;
                end
            end
            ST_DAY: begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = DIV_DAY;
                if (stat.div_last) begin
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR: begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = DIV_HOUR;
                if (stat.div_last) begin
                    state_next = ST_MIN;
                end
            end
            ST_MIN: begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = DIV_MIN;
                if (stat.div_last) begin
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (stat.yr_fits) begin
                    state_next = ST_MONTH;
                end else begin
                    cmd.yr_step = 1'b1;
                end
            end
            ST_MONTH: begin
                if (stat.mo_fits) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.mo_step = 1'b1;
                end
            end
            ST_OUT: begin
                // wait until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: rtl/es2cal_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2cal_dp
// Datapath: reciprocal-multiply division for days, hours and minutes, year
// and month subtraction loops with leap tracking, and the result register.
// ----------------------------------------------------------------------------
module es2cal_dp
    import es2cal_pkg::*;
(
    input  logic              aclk,
    input  logic [EpochW-1:0] epoch_in,
    input  cmd_t              cmd,
    output stat_t             stat,
    output logic              time_valid_o,
    output logic [YearW-1:0]  year_o,
    output logic [MonthW-1:0] month_o,
    output logic [DayW-1:0]   day_o,
    output logic [HourW-1:0]  hour_o,
    output logic [MinW-1:0]   minute_o
);

    // division
    logic [EpochW-1:0]    epoch_reg;
    logic [RemW-1:0]      rem_reg;
    logic                 ph_reg;
    logic [DayProdW-1:0]  day_prod;
    logic [HourProdW-1:0] hour_prod;
    logic [MinProdW-1:0]  min_prod;
    logic [DaysW-1:0]     day_q;
    logic [HourW-1:0]     hour_q;
    logic [MinW-1:0]      min_q;
    logic [EpochW-1:0]    day_rem;
    logic [RemW-1:0]      hour_rem;

    // calendar state
    logic              nz_reg;
    logic [DaysW-1:0]  days_reg;
    logic [HourW-1:0]  hour_reg;
    logic [MinW-1:0]   minute_reg;
    logic [YearW-1:0]  year_reg;
    logic [6:0]        m100_reg;
    logic [8:0]        m400_reg;
    logic [MonthW-1:0] mo_reg;
    logic              leap;
    logic [YlenW-1:0]  ylen;
    logic [DayW-1:0]   mlen;

    // result register
    logic              tv_reg;
    logic [YearW-1:0]  year_out_reg;
    logic [MonthW-1:0] month_out_reg;
    logic [DayW-1:0]   day_out_reg;
    logic [HourW-1:0]  hour_out_reg;
    logic [MinW-1:0]   minute_out_reg;

    // quotients
    assign day_prod  = DayProdW'(epoch_reg[EpochW-1:DayPreShift]) * DayProdW'(DayRecip);
    assign day_q     = day_prod[DayShift +: DaysW];
    assign hour_prod = HourProdW'(rem_reg[RemW-1:HourPreShift]) * HourProdW'(HourRecip);
    assign hour_q    = hour_prod[HourShift +: HourW];
    assign min_prod  = MinProdW'(rem_reg[MinRemW-1:MinPreShift]) * MinProdW'(MinRecip);
    assign min_q     = min_prod[MinShift +: MinW];

    // remainders from the registered quotients
    assign day_rem  = epoch_reg - EpochW'(days_reg) * EpochW'(SecsPerDay);
    assign hour_rem = rem_reg - RemW'(hour_reg) * RemW'(SecsPerHour);

    assign leap = (year_reg[1:0] == 2'b00) && ((m100_reg != 7'd0) || (m400_reg == 9'd0));
    assign ylen = leap ? YlenW'(366) : YlenW'(365);
    assign mlen = month_len(mo_reg, leap);

    assign stat.div_last = ph_reg;
    assign stat.yr_fits  = (days_reg < DaysW'(ylen));
    assign stat.mo_fits  = (days_reg < DaysW'(mlen)) || (mo_reg == LastMonth);

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            epoch_reg <= epoch_in;
            ph_reg    <= 1'b0;
            nz_reg    <= (epoch_in != '0);
            year_reg  <= YearW'(BaseYear);
            m100_reg  <= 7'(BaseMod100);
            m400_reg  <= 9'(BaseMod400);
            mo_reg    <= '0;
        end else if (cmd.div_step) begin
            if (!ph_reg) begin
                case (cmd.div_sel)
                    DIV_DAY:  days_reg   <= day_q;
                    DIV_HOUR: hour_reg   <= hour_q;
                    default:  minute_reg <= min_q;
                endcase
                ph_reg <= 1'b1;
            end else begin
                // carry the remainder into the next pass
                case (cmd.div_sel)
                    DIV_DAY:  rem_reg <= day_rem[RemW-1:0];
                    DIV_HOUR: rem_reg <= hour_rem;
                    default:  rem_reg <= rem_reg;
                endcase
                ph_reg <= 1'b0;
            end
        end else if (cmd.yr_step) begin
            days_reg <= days_reg - DaysW'(ylen);
            year_reg <= year_reg + YearW'(1);
            m100_reg <= (m100_reg == 7'd99)  ? 7'd0 : m100_reg + 7'd1;
            m400_reg <= (m400_reg == 9'd399) ? 9'd0 : m400_reg + 9'd1;
        end else if (cmd.mo_step) begin
            days_reg <= days_reg - DaysW'(mlen);
            mo_reg   <= mo_reg + MonthW'(1);
        end
    end

    // zero input gives an all-zero result
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            tv_reg         <= nz_reg;
            year_out_reg   <= nz_reg ? year_reg : '0;
            month_out_reg  <= nz_reg ? MonthW'(mo_reg + MonthW'(1)) : '0;
            day_out_reg    <= nz_reg ? DayW'(days_reg[DayW-1:0] + DayW'(1)) : '0;
            hour_out_reg   <= nz_reg ? hour_reg : '0;
            minute_out_reg <= nz_reg ? minute_reg : '0;
        end
    end

    assign time_valid_o = tv_reg;
    assign year_o       = year_out_reg;
    assign month_o      = month_out_reg;
    assign day_o        = day_out_reg;
    assign hour_o       = hour_out_reg;
    assign minute_o     = minute_out_reg;

endmodule

FILE: rtl/epoch_seconds_to_calendar_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00 UTC to
// Gregorian year, month, day of month, hour and minute.
// ----------------------------------------------------------------------------
// One timestamp is converted at a time. From acceptance to the result
// register the converter runs the day, hour and minute division passes,
// the year loop over the whole years since 1970 and the month loop over the
// whole months into that year. Reciprocal multiplication gives the day,
// hour and minute quotients; each pass registers a quotient and then its
// remainder. The year loop takes one year per cycle. The next timestamp is
// taken in the cycle after the result register loads. A finished result
// waits in the output register until m_tready; a second finished result
// holds the converter, and with it the input, until the first transfer. A
// zero input gives m_tuser low and an all-zero m_tdata.
module epoch_seconds_to_calendar_top
    import es2cal_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] epoch_seconds
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [11:0] year, [15:12] month, [20:16] day_of_month,
                                   // [25:21] hour, [31:26] minute
    output logic        m_tuser    // [0] time_valid
);

    cmd_t              cmd;
    stat_t             stat;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day_of_month;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;

    es2cal_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    es2cal_dp u_dp (
        .aclk         (aclk),
        .epoch_in     (s_tdata),
        .cmd          (cmd),
        .stat         (stat),
        .time_valid_o (m_tuser),
        .year_o       (year),
        .month_o      (month),
        .day_o        (day_of_month),
        .hour_o       (hour),
        .minute_o     (minute)
    );

    assign m_tdata = {minute, hour, day_of_month, month, year};

endmodule

FILE: tb/calendar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_checker
// Watches both stream channels of the epoch to calendar converter, predicts
// the date and time of day for every accepted timestamp and compares each
// result transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module calendar_checker
    import es2cal_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [31:0]       s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [31:0]       m_tdata,
    input  logic              m_tuser,
    output int unsigned       mismatches,
    output int unsigned       pending_dates,
    output int unsigned       dates_checked,
    output int unsigned       zero_stamps,
    output logic [YearW-1:0]  earliest_year,
    output logic [YearW-1:0]  latest_year
);

    typedef struct packed {
        logic              time_valid;
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
        logic [HourW-1:0]  hour;
        logic [MinW-1:0]   minute;
    } cal_date_t;

    // Month lengths, January in the lowest five bits
    localparam logic [12*5-1:0] MonthLengths = {
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
        5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31
    };

    cal_date_t expected_dates [$];
    int unsigned err_n   = 0;
    int unsigned done_n  = 0;
    int unsigned zero_n  = 0;
    logic [YearW-1:0] yr_lo = '1;
    logic [YearW-1:0] yr_hi = '0;

    function automatic bit is_leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic cal_date_t epoch_to_date(input logic [31:0] secs);
        cal_date_t   d;
        int unsigned days;
        int unsigned yr;
        int unsigned year_len;
        int unsigned mo;
        int unsigned mo_len;
        bit          leap;
        d = '0;
        if (secs == 32'd0) begin
            return d;
        end
        days     = secs / SecsPerDay;
        yr       = BaseYear;
        year_len = is_leap_year(yr) ? 366 : 365;
        while (days >= year_len) begin
            days     -= year_len;
            yr       += 1;
            year_len  = is_leap_year(yr) ? 366 : 365;
        end
        leap   = (year_len == 366);
        mo     = 0;
        mo_len = 32'(MonthLengths[4:0]);
        // December takes whatever is left
        while (mo < 11 && days >= mo_len) begin
            days   -= mo_len;
            mo     += 1;
            mo_len  = 32'(MonthLengths[mo*5 +: 5]) + ((mo == 1 && leap) ? 1 : 0);
        end
        d.time_valid = 1'b1;
        d.year       = YearW'(yr);
        d.month      = MonthW'(mo + 1);
        d.day        = DayW'(days + 1);
        d.hour       = HourW'((secs / SecsPerHour) % 24);
        d.minute     = MinW'((secs / SecsPerMin) % 60);
        return d;
    endfunction

    always @(posedge aclk) begin
        cal_date_t got;
        cal_date_t want;
        if (aresetn) begin
            // Pop before push so that a stray result never matches a fresh stamp
            if (m_tvalid && m_tready) begin
                got.time_valid = m_tuser;
                got.year       = m_tdata[11:0];
                got.month      = m_tdata[15:12];
                got.day        = m_tdata[20:16];
                got.hour       = m_tdata[25:21];
                got.minute     = m_tdata[31:26];
                if (expected_dates.size() == 0) begin
                    err_n++;
                    if (err_n <= 10)
                        $display("%t: result transfer with nothing pending:", $realtime,
                                 " v=%b %0d-%0d-%0d %0d:%0d", got.time_valid, got.year,
                                 got.month, got.day, got.hour, got.minute);
                end else begin
                    want = expected_dates.pop_front();
                    done_n++;
                    if (!want.time_valid)
                        zero_n++;
                    else begin
                        if (want.year < yr_lo) yr_lo = want.year;
                        if (want.year > yr_hi) yr_hi = want.year;
                    end
                    if (got.time_valid !== want.time_valid || got.year !== want.year ||
                        got.month !== want.month || got.day !== want.day ||
                        got.hour !== want.hour || got.minute !== want.minute) begin
                        err_n++;
                        if (err_n <= 10)
                            $display("%t: date mismatch:", $realtime,
                                     " expected v=%b %0d-%0d-%0d %0d:%0d,",
                                     want.time_valid, want.year, want.month,
                                     want.day, want.hour, want.minute,
                                     " got v=%b %0d-%0d-%0d %0d:%0d", got.time_valid,
                                     got.year, got.month, got.day, got.hour, got.minute);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_dates.push_back(epoch_to_date(s_tdata));
        end
        mismatches    <= err_n;
        pending_dates <= expected_dates.size();
        dates_checked <= done_n;
        zero_stamps   <= zero_n;
        earliest_year <= yr_lo;
        latest_year   <= yr_hi;
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives timestamps into the epoch to calendar converter: corner dates first,
// then random stamps biased toward year starts and leap days, under
// several patterns of sender gaps and receiver stalls, plus one long result
// hold-off that backs up the input. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import es2cal_pkg::*;

    localparam int NumCorners     = 24;
    localparam int RandomPerPhase = 332;
    localparam int HoldCycles     = 400;
    localparam int DrainCycles    = 250;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // [11:0] year, [15:12] month, [20:16] day_of_month,
                            // [25:21] hour, [31:26] minute
    logic        m_tuser;   // [0] time_valid

    int unsigned      send_idle_pct  = 0;
    int unsigned      recv_stall_pct = 0;
    logic             hold_request   = 1'b0;
    int unsigned      hold_left      = 0;

    int unsigned      mismatches;
    int unsigned      pending_dates;
    int unsigned      dates_checked;
    int unsigned      zero_stamps;
    logic [YearW-1:0] earliest_year;
    logic [YearW-1:0] latest_year;

    // Epoch origin, minute/hour/day edges, leap days of 1972, 2000 and the
    // skipped one of 2100, year ends, the top of the range and bit patterns
    logic [31:0] corner_epochs [0:NumCorners-1] = '{
        32'd0,          32'd1,          32'd59,         32'd60,
        32'd3600,       32'd86399,      32'd86400,      32'd68169599,
        32'd68169600,   32'd68256000,   32'd94694399,   32'd946684799,
        32'd946684800,  32'd951782400,  32'd951868800,  32'd4107542399,
        32'd4107542400, 32'd4291747199, 32'd4291747200, 32'h7FFF_FFFF,
        32'h8000_0000,  32'h5555_5555,  32'hAAAA_AAAA,  32'hFFFF_FFFF
    };

    epoch_seconds_to_calendar_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    calendar_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .mismatches    (mismatches),
        .pending_dates (pending_dates),
        .dates_checked (dates_checked),
        .zero_stamps   (zero_stamps),
        .earliest_year (earliest_year),
        .latest_year   (latest_year)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Result side: random stalls, or a long hold-off when requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_request) begin
            hold_left <= HoldCycles;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic send_epoch(input logic [31:0] secs);
        s_tdata  <= secs;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Half plain 32-bit values; the rest land near year starts, leap days,
    // small counts, the top of the range, or sparse bit patterns
    function automatic logic [31:0] pick_epoch();
        int unsigned kind;
        int unsigned yr;
        int unsigned days;
        int unsigned secs;
        kind = $urandom_range(9);
        case (kind)
            5, 6: begin
                yr   = $urandom_range(2105, 1971);
                days = (yr - 1970) * 365 + (yr - 1) / 4 - (yr - 1) / 100
                       + (yr - 1) / 400 - 477;
                case ($urandom_range(3))
                    0:       days = days - 1;
                    1:       days = days;
                    2:       days = days + 58 + $urandom_range(1);
                    default: days = days + $urandom_range(364);
                endcase
                secs = days * 86400 + $urandom_range(86399);
                return secs;
            end
            7:       return $urandom_range(200000);
            8:       return 32'hFFFF_FFFF - $urandom_range(40000000);
            9:       return ($urandom_range(3) == 0) ? 32'd0 : ($urandom & $urandom & $urandom);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NumCorners; i++)
            send_epoch(corner_epochs[i]);

        // Block the result side and keep offering until the input stalls
        hold_request <= 1'b1;
        @(posedge aclk);
        hold_request <= 1'b0;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 78; end
                default: begin send_idle_pct = 18; recv_stall_pct <= 18; end
            endcase
            for (int n = 0; n < RandomPerPhase; n++)
                send_epoch(pick_epoch());
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending_dates != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        $display("Converted %0d timestamps, %0d of them zero, valid years %0d to %0d.",
                 dates_checked, zero_stamps, earliest_year, latest_year);
        $display("Traffic: no gaps, sparse input, stalled output, mixed, one %0d-cycle hold-off.",
                 HoldCycles);
        if (mismatches == 0 && pending_dates == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches, pending_dates);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
